// ===== hdl/wtsp_pkg.sv =====
// shared types and constants of the world-to-screen projection block
// no dependencies; used by the dot row, divider cell and top level modules of the block
`timescale 1ns / 1ps
`default_nettype none

package wtsp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [2:0] REG_ROW3_COLS01 = 3'd4;
  localparam logic [2:0] REG_ROW3_COLS23 = 3'd5;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 64;

  // behind-the-viewer scaling: largest magnitude that survives the scale
  localparam int unsigned BEHIND_SCALE = 100000;
  localparam int unsigned BEHIND_LIM   = 21474;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // per-item control carried along the divider cells
  typedef struct packed {
    logic       behind;
    logic [1:0] neg;
    logic [1:0] ovf;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/wtsp_dot_row.sv =====
// one matrix row dotted with (x, y, z, 1): product stage and sum stage
// depends on wtsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wtsp_dot_row #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DW        = 66 - FRAC_BITS
) (
  input  wire                     clk_i,
  input  wire                     prod_en_i,
  input  wire                     sum_en_i,
  input  wire [wtsp_pkg::CFG_W-1:0] c01_i,
  input  wire [wtsp_pkg::CFG_W-1:0] c23_i,
  input  wire signed [31:0]       px_i,
  input  wire signed [31:0]       py_i,
  input  wire signed [31:0]       pz_i,
  output logic signed [DW-1:0]    dot_o
);

  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [31:0] c3_q;
  logic signed [65:0] sum;

  // products, one multiplier per x, y and z column; column 3 is only registered
  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      p0_q <= $signed(c01_i[63:32]) * px_i;
      p1_q <= $signed(c01_i[31:0]) * py_i;
      p2_q <= $signed(c23_i[63:32]) * pz_i;
      c3_q <= $signed(c23_i[31:0]);
    end
  end

  // exact sum at 2*FRAC_BITS fraction bits, then floor
  always_comb begin
    sum = 66'(p0_q) + 66'(p1_q) + 66'(p2_q) + (66'(c3_q) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      dot_o <= sum[65:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wtsp_div_cell.sv =====
// one restoring-division cell: one quotient bit per lane, then hand on
// depends on wtsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wtsp_div_cell #(
  parameter int unsigned RW = 51
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire                   ready_i,
  input  wire wtsp_pkg::ctl_t   ctl_i,
  input  wire [RW-1:0]          den_i,
  input  wire [1:0][RW-1:0]     rem_i,
  input  wire [1:0][31:0]       bits_i,
  input  wire [1:0][31:0]       quo_i,
  output wtsp_pkg::ctl_t        ctl_o,
  output logic [RW-1:0]         den_o,
  output logic [1:0][RW-1:0]    rem_o,
  output logic [1:0][31:0]      bits_o,
  output logic [1:0][31:0]      quo_o
);

  logic [1:0][RW-1:0] rem_d;
  logic [1:0][31:0]   bits_d, quo_d;
  logic [RW-1:0]      trial;

  assign ready_o = !valid_o || ready_i;

  // shift in next dividend bit, compare and subtract; behind items pass through unchanged
  always_comb begin
    trial = '0;
    for (int j = 0; j < 2; j++) begin
      rem_d[j]  = rem_i[j];
      bits_d[j] = bits_i[j];
      quo_d[j]  = quo_i[j];
      if (!ctl_i.behind) begin
        trial     = {rem_i[j][RW-2:0], bits_i[j][31]};
        bits_d[j] = {bits_i[j][30:0], 1'b0};
        if (trial >= den_i) begin
          rem_d[j] = trial - den_i;
          quo_d[j] = {quo_i[j][30:0], 1'b1};
        end else begin
          rem_d[j] = trial;
          quo_d[j] = {quo_i[j][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_o  <= ctl_i;
      den_o  <= den_i;
      rem_o  <= rem_d;
      bits_o <= bits_d;
      quo_o  <= quo_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/world_to_screen_projection.sv =====
// top level of the world-to-screen projection: config, dot rows, divider chain
// depends on wtsp_pkg, wtsp_dot_row, wtsp_div_cell
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | point_x_i, point_y_i, point_z_i
//  out     | output    | out_valid_o/out_ready_i | screen_x_o, screen_y_o, behind_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one point per cycle while the output is not stalled; registers are product, sum, setup,
// 32 divider cells and the output register, with one quotient bit per divider cell
// reset clears all valid bits and loads the matrix reset values
// every stage holds when full and its successor is stalled; bubbles collapse
`timescale 1ns / 1ps
`default_nettype none

module world_to_screen_projection #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] point_x_i,
  input  wire  [31:0] point_y_i,
  input  wire  [31:0] point_z_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] screen_x_o,
  output logic [31:0] screen_y_o,
  output logic        behind_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);

  localparam int unsigned DW    = 66 - FRAC_BITS;
  localparam int unsigned RW    = DW + 1;
  localparam int unsigned SH    = 32 - FRAC_BITS;
  localparam int unsigned NCELL = 32;
  localparam logic signed [DW-1:0] W_THRESH = DW'(((2 ** FRAC_BITS) + 999) / 1000);
  localparam logic signed [DW-1:0] LIM_P    = DW'(wtsp_pkg::BEHIND_LIM);
  localparam logic signed [DW-1:0] LIM_N    = -LIM_P;
  localparam logic [63:0] ONE_HI = 64'(1) << (32 + FRAC_BITS);
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;

  // configuration registers
  logic [63:0] r0c01_q, r0c23_q, r1c01_q, r1c23_q, r3c01_q, r3c23_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0c01_q <= ONE_HI;
      r0c23_q <= '0;
      r1c01_q <= ONE_LO;
      r1c23_q <= '0;
      r3c01_q <= '0;
      r3c23_q <= ONE_LO;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wtsp_pkg::REG_ROW0_COLS01: r0c01_q <= cfg_data_i;
        wtsp_pkg::REG_ROW0_COLS23: r0c23_q <= cfg_data_i;
        wtsp_pkg::REG_ROW1_COLS01: r1c01_q <= cfg_data_i;
        wtsp_pkg::REG_ROW1_COLS23: r1c23_q <= cfg_data_i;
        wtsp_pkg::REG_ROW3_COLS01: r3c01_q <= cfg_data_i;
        wtsp_pkg::REG_ROW3_COLS23: r3c23_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front stage handshake
  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;
  logic out_rdy;
  logic [NCELL:0] c_valid, c_ready;

  assign out_rdy    = !out_valid_o || out_ready_i;
  assign r3         = !v3_q || c_ready[0];
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // three dot products
  logic signed [DW-1:0] dot_x, dot_y, dot_w;
  logic prod_en, sum_en;

  assign prod_en = r1 && in_valid_i;
  assign sum_en  = r2 && v1_q;

  wtsp_dot_row #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_row_x (
    .clk_i, .prod_en_i(prod_en), .sum_en_i(sum_en), .c01_i(r0c01_q), .c23_i(r0c23_q),
    .px_i(point_x_i), .py_i(point_y_i), .pz_i(point_z_i), .dot_o(dot_x)
  );
  wtsp_dot_row #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_row_y (
    .clk_i, .prod_en_i(prod_en), .sum_en_i(sum_en), .c01_i(r1c01_q), .c23_i(r1c23_q),
    .px_i(point_x_i), .py_i(point_y_i), .pz_i(point_z_i), .dot_o(dot_y)
  );
  wtsp_dot_row #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_row_w (
    .clk_i, .prod_en_i(prod_en), .sum_en_i(sum_en), .c01_i(r3c01_q), .c23_i(r3c23_q),
    .px_i(point_x_i), .py_i(point_y_i), .pz_i(point_z_i), .dot_o(dot_w)
  );

  // divider setup: threshold, magnitudes, overflow check, behind scaling
  wtsp_pkg::ctl_t       ctl_d;
  logic [RW-1:0]        den_d;
  logic [1:0][RW-1:0]   rem_d;
  logic [1:0][31:0]     bits_d, quo_d;
  logic signed [DW-1:0] lane [2];
  logic [DW-1:0]        mag;
  logic [RW-1:0]        top;
  logic signed [31:0]   scaled;

  assign lane[0] = dot_x;
  assign lane[1] = dot_y;

  always_comb begin
    ctl_d.behind = dot_w < W_THRESH;
    den_d        = RW'(unsigned'(dot_w));
    mag          = '0;
    top          = '0;
    scaled       = '0;
    for (int j = 0; j < 2; j++) begin
      ctl_d.neg[j] = lane[j][DW-1];
      mag          = lane[j][DW-1] ? DW'(-lane[j]) : DW'(lane[j]);
      top          = RW'(mag >> SH);
      ctl_d.ovf[j] = !ctl_d.behind && (top >= den_d);
      rem_d[j]     = ctl_d.ovf[j] ? '0 : top;
      bits_d[j]    = {mag[SH-1:0], {FRAC_BITS{1'b0}}};
      scaled       = $signed(lane[j][31:0]) * $signed(32'(wtsp_pkg::BEHIND_SCALE));
      if (lane[j] > LIM_P) begin
        quo_d[j] = wtsp_pkg::SAT_MAX;
      end else if (lane[j] < LIM_N) begin
        quo_d[j] = wtsp_pkg::SAT_MIN;
      end else begin
        quo_d[j] = ctl_d.behind ? unsigned'(scaled) : '0;
      end
      if (!ctl_d.behind) begin
        quo_d[j] = '0;
      end
    end
  end

  // cell chain
  wtsp_pkg::ctl_t     c_ctl  [NCELL+1];
  logic [RW-1:0]      c_den  [NCELL+1];
  logic [1:0][RW-1:0] c_rem  [NCELL+1];
  logic [1:0][31:0]   c_bits [NCELL+1];
  logic [1:0][31:0]   c_quo  [NCELL+1];

  assign c_valid[0]     = v3_q;
  assign c_ready[NCELL] = out_rdy;

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      c_ctl[0]  <= ctl_d;
      c_den[0]  <= den_d;
      c_rem[0]  <= rem_d;
      c_bits[0] <= bits_d;
      c_quo[0]  <= quo_d;
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    wtsp_div_cell #(.RW(RW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(c_valid[k]), .ready_o(c_ready[k]),
      .valid_o(c_valid[k+1]), .ready_i(c_ready[k+1]),
      .ctl_i(c_ctl[k]), .den_i(c_den[k]), .rem_i(c_rem[k]),
      .bits_i(c_bits[k]), .quo_i(c_quo[k]),
      .ctl_o(c_ctl[k+1]), .den_o(c_den[k+1]), .rem_o(c_rem[k+1]),
      .bits_o(c_bits[k+1]), .quo_o(c_quo[k+1])
    );
  end

  // sign and saturation of the quotients
  logic [1:0][31:0] res_d;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      priority if (c_ctl[NCELL].behind) begin
        res_d[j] = c_quo[NCELL][j];
      end else if (c_ctl[NCELL].ovf[j]) begin
        res_d[j] = c_ctl[NCELL].neg[j] ? wtsp_pkg::SAT_MIN : wtsp_pkg::SAT_MAX;
      end else if (c_ctl[NCELL].neg[j]) begin
        res_d[j] = (c_quo[NCELL][j] > wtsp_pkg::SAT_MIN) ? wtsp_pkg::SAT_MIN
                                                         : 32'(-c_quo[NCELL][j]);
      end else begin
        res_d[j] = c_quo[NCELL][j][31] ? wtsp_pkg::SAT_MAX : c_quo[NCELL][j];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_rdy) begin
      out_valid_o <= c_valid[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && c_valid[NCELL]) begin
      screen_x_o <= res_d[0];
      screen_y_o <= res_d[1];
      behind_o   <= c_ctl[NCELL].behind;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wtsp_checker.sv =====
// port-level checks of the world-to-screen projection and their bind
// depends on world_to_screen_projection
`timescale 1ns / 1ps
`default_nettype none

module wtsp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [31:0] screen_x_o,
  input wire [31:0] screen_y_o,
  input wire        behind_o,
  input wire        cfg_ready_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o)
      && $stable(screen_y_o) && $stable(behind_o))
    else $error("result changed while stalled");

  // with the output register empty the whole chain can move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a result transfer frees the input side in the same cycle
  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while result transfers");

  // configuration is never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .screen_x_o, .screen_y_o, .behind_o, .cfg_ready_o
);

`default_nettype wire

// ===== dv/world_to_screen_projection_test.sv =====
// testbench of the world-to-screen projection block: directed and random points
// checked against a fixed-point predictor; depends on wtsp_pkg and the block rtl
`timescale 1ns / 1ps

module world_to_screen_projection_test;

  localparam int unsigned FRAC   = 16;
  localparam int          W_MIN  = 66;          // ceil(0.001 * 2^16)
  localparam int          LAT    = 40;
  localparam int          WDOG   = 5000;
  localparam int          HOLD   = 400;
  localparam logic [2:0]  REG_SPARE6 = 3'd6;
  localparam logic [2:0]  REG_SPARE7 = 3'd7;
  localparam logic [31:0] ONE    = 32'h0001_0000;
  localparam logic [31:0] M_ONE  = 32'hffff_0000;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        behind;
  } screen_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [31:0] point_x_i, point_y_i, point_z_i;
  logic        out_valid_o, out_ready_i;
  logic [31:0] screen_x_o, screen_y_o;
  logic        behind_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  // matrix copy, expected screen points, counters
  logic [63:0] matrix [6];
  screen_t     pending_screen[$];
  int          mismatches, points_sent, points_seen, behind_seen, cfg_writes;
  int          burst_left, idle_cycles, hold_left;
  bit          hold_req, calm;

  world_to_screen_projection DUT (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one dot product row, exact then floored to FRAC bits
  function automatic logic signed [71:0] dot_row(logic [63:0] c01, logic [63:0] c23,
                                                 logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
    logic signed [71:0] a0, a1, a2, a3, x, y, z, acc;
    a0 = $signed(c01[63:32]);
    a1 = $signed(c01[31:0]);
    a2 = $signed(c23[63:32]);
    a3 = $signed(c23[31:0]);
    x = $signed(px);
    y = $signed(py);
    z = $signed(pz);
    acc = a0 * x + a1 * y + a2 * z + (a3 <<< FRAC);
    return acc >>> FRAC;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [71:0] v);
    if (v > 72'sh7fff_ffff) return wtsp_pkg::SAT_MAX;
    if (v < -72'sh8000_0000) return wtsp_pkg::SAT_MIN;
    return v[31:0];
  endfunction

  // behind path scale and the fixed-point divide
  function automatic logic [31:0] push_out(logic signed [71:0] v);
    if (v > $signed(72'(wtsp_pkg::BEHIND_LIM))) return wtsp_pkg::SAT_MAX;
    if (v < -$signed(72'(wtsp_pkg::BEHIND_LIM))) return wtsp_pkg::SAT_MIN;
    return clamp32(v * $signed(72'(wtsp_pkg::BEHIND_SCALE)));
  endfunction

  function automatic logic [31:0] fx_divide(logic signed [71:0] num, logic signed [71:0] den);
    logic [79:0] n, d, mag;
    n = (num < 0) ? 80'(-num) : 80'(num);
    d = 80'(den);
    if (n / d >= (80'd1 << (32 - FRAC)))
      return (num < 0) ? wtsp_pkg::SAT_MIN : wtsp_pkg::SAT_MAX;
    mag = (n << FRAC) / d;
    return (num < 0) ? clamp32(-$signed(72'(mag))) : clamp32($signed(72'(mag)));
  endfunction

  function automatic screen_t project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic signed [71:0] x, y, w;
    screen_t s;
    x = dot_row(matrix[0], matrix[1], px, py, pz);
    y = dot_row(matrix[2], matrix[3], px, py, pz);
    w = dot_row(matrix[4], matrix[5], px, py, pz);
    s.behind = (w < W_MIN);
    s.sx = s.behind ? push_out(x) : fx_divide(x, w);
    s.sy = s.behind ? push_out(y) : fx_divide(y, w);
    return s;
  endfunction

  // random coordinate: full range, small magnitude or an extreme
  function automatic logic [31:0] rand_coord();
    unique case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3:       return wtsp_pkg::SAT_MAX;
      4:       return wtsp_pkg::SAT_MIN;
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h (point %0d)", what, got, want, points_seen);
  endtask

  // one point transfer, with burst and gap pacing on the sender side
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    pending_screen.push_back(project(px, py, pz));
    points_sent++;
  endtask

  // drop valid, then wait for the pipeline to empty
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_screen.size() > 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= wtsp_pkg::REG_ROW3_COLS23) matrix[idx] = val;
    cfg_writes++;
  endtask

  task automatic load_matrix(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                             logic [63:0] r1b, logic [63:0] r3a, logic [63:0] r3b);
    write_reg(wtsp_pkg::REG_ROW0_COLS01, r0a);
    write_reg(wtsp_pkg::REG_ROW0_COLS23, r0b);
    write_reg(wtsp_pkg::REG_ROW1_COLS01, r1a);
    write_reg(wtsp_pkg::REG_ROW1_COLS23, r1b);
    write_reg(wtsp_pkg::REG_ROW3_COLS01, r3a);
    write_reg(wtsp_pkg::REG_ROW3_COLS23, r3b);
  endtask

  // reset matrix passes x and y straight through with w of one
  task automatic test_reset_matrix();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MIN, 32'h1234_5678);
    send_point(wtsp_pkg::SAT_MIN, wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MIN);
    send_point(ONE, M_ONE, wtsp_pkg::SAT_MAX);
    send_point(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
    drain();
  endtask

  // behind threshold, behind scaling and its saturation, ignored indexes
  task automatic test_behind_path();
    load_matrix({ONE, 32'h0}, 64'h0, {32'h0, ONE}, 64'h0, 64'h0, {32'h0, 32'd65});
    write_reg(REG_SPARE6, '1);
    write_reg(REG_SPARE7, 64'h0);
    send_point(32'd21474, 32'hffff_ac1e, 32'h0);   // just inside the scale limit
    send_point(32'd21475, 32'hffff_ac1d, 32'h0);   // just outside
    send_point(wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MIN, 32'h0);
    send_point(32'h0000_0003, M_ONE, 32'h0);
    drain();
    // w exactly at threshold, then w negative from z
    write_reg(wtsp_pkg::REG_ROW3_COLS23, {32'h0, 32'd66});
    send_point(wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MIN, 32'h0);
    send_point(32'd1, 32'hffff_ffff, 32'h0);
    drain();
    write_reg(wtsp_pkg::REG_ROW3_COLS23, {ONE, 32'd66});
    send_point(ONE, ONE, M_ONE);
    send_point(ONE, ONE, 32'h0000_0001);
    drain();
  endtask

  // perspective matrix and divide saturation, then extreme coefficients
  task automatic test_divide_path();
    load_matrix({32'h0001_8000, 32'h0}, {32'h0, 32'h0000_8000},
                {32'h0, 32'h0002_0000}, {32'hffff_8000, 32'h0},
                64'h0, {ONE, 32'h0});
    send_point(ONE, ONE, 32'h000a_0000);
    send_point(M_ONE, 32'h0003_0000, 32'h0000_0042);
    send_point(wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MIN, 32'h0000_0042);
    send_point(32'h0100_0000, M_ONE, 32'h0001_0000);
    drain();
    load_matrix('1, {wtsp_pkg::SAT_MIN, wtsp_pkg::SAT_MIN},
                {wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MAX},
                {wtsp_pkg::SAT_MIN, wtsp_pkg::SAT_MAX},
                {wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MIN},
                {wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MAX});
    send_point(wtsp_pkg::SAT_MIN, wtsp_pkg::SAT_MIN, wtsp_pkg::SAT_MIN);
    send_point(wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MAX, wtsp_pkg::SAT_MAX);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  // random matrices, mostly in front of the viewer, with random points
  task automatic test_random_scenes(int phases, int per_phase);
    logic [63:0] r [6];
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < 6; i++)
        r[i] = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
             : {rand_coord() >>> 4, rand_coord() >>> 4};
      if (p % 3 != 2) r[5][31:0] = $urandom_range(32'h0000_0100, 32'h0100_0000);
      load_matrix(r[0], r[1], r[2], r[3], r[4], r[5]);
      calm = (p % 4 == 3);
      for (int n = 0; n < per_phase; n++)
        send_point(rand_coord(), rand_coord(), rand_coord());
      calm = 1'b0;
      drain();
    end
  endtask

  // receiver holds off while points keep coming, so the input stalls
  task automatic test_backpressure();
    load_matrix({ONE, 32'h0}, 64'h0, {32'h0, ONE}, 64'h0, 64'h0, {32'h0, ONE});
    hold_req = 1'b1;
    calm = 1'b1;
    for (int n = 0; n < 120; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    calm = 1'b0;
    drain();
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    matrix = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
               64'h0, 64'h0000_0000_0001_0000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrix();
    test_behind_path();
    test_divide_path();
    test_backpressure();
    test_random_scenes(8, 60);
    $display("covered %0d points (%0d behind the viewer), %0d register writes",
             points_sent, behind_seen, cfg_writes);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 9) < 7);
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    screen_t s;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG) begin
        $display("timeout with %0d results outstanding", pending_screen.size());
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        points_seen++;
        if (pending_screen.size() == 0) begin
          report("unexpected result", screen_x_o, '0);
        end else begin
          s = pending_screen.pop_front();
          if (screen_x_o !== s.sx) report("screen_x", screen_x_o, s.sx);
          if (screen_y_o !== s.sy) report("screen_y", screen_y_o, s.sy);
          if (behind_o !== s.behind) report("behind", 32'(behind_o), 32'(s.behind));
          if (s.behind) behind_seen++;
        end
      end
    end
  end

endmodule
